[hw/rtl/ttrk_pkg.sv]
// Touch point tracker package: constants, register codes and the structs
// shared by the tracker core, the configuration block and the top level.
// No dependencies.
`timescale 1ns / 1ps

package ttrk_pkg;

  // Zero-finger polls needed to complete a release
  localparam logic [1:0] REL_SAMPLES = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SWAP_AXES    = 3'd0,
    CFG_FLIP_X       = 3'd1,
    CFG_FLIP_Y       = 3'd2,
    CFG_PANEL_WIDTH  = 3'd3,
    CFG_PANEL_HEIGHT = 3'd4
  } cfg_idx_t;

  // Panel size reset values
  localparam logic [12:0] PANEL_WIDTH_RST  = 13'd240;
  localparam logic [12:0] PANEL_HEIGHT_RST = 13'd280;

  // Input item kinds
  localparam logic MODE_IRQ  = 1'b0;
  localparam logic MODE_POLL = 1'b1;

  // Slide classes
  localparam logic [1:0] CLS_CLICK   = 2'd0;
  localparam logic [1:0] CLS_PRESSED = 2'd1;
  localparam logic [1:0] CLS_SLIDED  = 2'd2;

  // Raw coordinate high byte keeps its low nibble
  localparam logic [7:0] COORD_HI_MASK = 8'h0f;

  typedef struct packed {
    logic        swap_axes;
    logic        flip_x;
    logic        flip_y;
    logic [12:0] panel_width;
    logic [12:0] panel_height;
  } ttrk_cfg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] finger_count;
    logic [7:0] x_high_byte;
    logic [7:0] x_low_byte;
    logic [7:0] y_high_byte;
    logic [7:0] y_low_byte;
  } ttrk_item_t;

  typedef struct packed {
    logic [7:0]  touch_state;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] now_x;
    logic [15:0] now_y;
    logic [15:0] end_x;
    logic [15:0] end_y;
    logic [1:0]  slide_class;
    logic        touch_began;
    logic        touch_ended;
  } ttrk_result_t;

  // True when two 16-bit points differ by at most one count, either way
  function automatic logic near_pt(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return (d <= 16'd1) || (d == 16'hffff);
  endfunction

endpackage

[hw/rtl/ttrk_cfg.sv]
// Configuration register file of the touch point tracker.
// Depends on ttrk_pkg.
`timescale 1ns / 1ps

module ttrk_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [ttrk_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [12:0]                        wr_data,
  output ttrk_pkg::ttrk_cfg_t                cfg
);

  ttrk_pkg::ttrk_cfg_t cfg_r;
  ttrk_pkg::ttrk_cfg_t cfg_nxt;

  // Decode the register index; unknown indexes change nothing
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        ttrk_pkg::CFG_SWAP_AXES:    cfg_nxt.swap_axes    = wr_data[0];
        ttrk_pkg::CFG_FLIP_X:       cfg_nxt.flip_x       = wr_data[0];
        ttrk_pkg::CFG_FLIP_Y:       cfg_nxt.flip_y       = wr_data[0];
        ttrk_pkg::CFG_PANEL_WIDTH:  cfg_nxt.panel_width  = wr_data;
        ttrk_pkg::CFG_PANEL_HEIGHT: cfg_nxt.panel_height = wr_data;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swap_axes    <= 1'b0;
      cfg_r.flip_x       <= 1'b0;
      cfg_r.flip_y       <= 1'b0;
      cfg_r.panel_width  <= ttrk_pkg::PANEL_WIDTH_RST;
      cfg_r.panel_height <= ttrk_pkg::PANEL_HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/ttrk_core.sv]
// Tracker state and per-item update: coordinate unpack, swap and flip,
// panel check, start/now/end points, release debounce and slide class.
// Depends on ttrk_pkg.
`timescale 1ns / 1ps

module ttrk_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  ttrk_pkg::ttrk_item_t   item,
  input  ttrk_pkg::ttrk_cfg_t    cfg,
  output ttrk_pkg::ttrk_result_t res
);

  logic        irq_pending_r, irq_pending_nxt;
  logic [1:0]  release_count_r, release_count_nxt;
  logic [7:0]  touching_count_r, touching_count_nxt;
  logic [7:0]  reported_count_r, reported_count_nxt;
  logic [15:0] start_x_r, start_y_r, start_x_nxt, start_y_nxt;
  logic [15:0] now_x_r, now_y_r, now_x_nxt, now_y_nxt;
  logic [15:0] end_x_r, end_y_r, end_x_nxt, end_y_nxt;

  logic [15:0] raw_a, raw_b, x_sel, y_sel, x_pt, y_pt;
  logic [15:0] width_ext, height_ext;
  logic [1:0]  rel_inc;
  logic        on_panel;
  logic        began, ended;
  logic [1:0]  cls;

  // Unpack, swap and flip the sampled point
  always_comb begin
    raw_a      = {4'd0, item.x_high_byte[3:0] & ttrk_pkg::COORD_HI_MASK[3:0],
                  item.x_low_byte};
    raw_b      = {4'd0, item.y_high_byte[3:0] & ttrk_pkg::COORD_HI_MASK[3:0],
                  item.y_low_byte};
    width_ext  = {3'd0, cfg.panel_width};
    height_ext = {3'd0, cfg.panel_height};
    x_sel      = cfg.swap_axes ? raw_b : raw_a;
    y_sel      = cfg.swap_axes ? raw_a : raw_b;
    x_pt       = cfg.flip_x ? (width_ext - x_sel) : x_sel;
    y_pt       = cfg.flip_y ? (height_ext - y_sel) : y_sel;
    on_panel   = (x_pt < width_ext) && (y_pt < height_ext);
    rel_inc    = release_count_r + 2'd1;
  end

  // Next tracker state for the current item
  always_comb begin
    irq_pending_nxt    = irq_pending_r;
    release_count_nxt  = release_count_r;
    touching_count_nxt = touching_count_r;
    reported_count_nxt = reported_count_r;
    start_x_nxt        = start_x_r;
    start_y_nxt        = start_y_r;
    now_x_nxt          = now_x_r;
    now_y_nxt          = now_y_r;
    end_x_nxt          = end_x_r;
    end_y_nxt          = end_y_r;
    began              = 1'b0;
    ended              = 1'b0;

    if (item.mode == ttrk_pkg::MODE_IRQ) begin
      irq_pending_nxt = 1'b1;
    end else if (!irq_pending_r) begin
      reported_count_nxt = 8'd0;
    end else if (item.finger_count == 8'd0) begin
      // Debounce the release
      release_count_nxt = rel_inc;
      if (rel_inc >= ttrk_pkg::REL_SAMPLES) begin
        release_count_nxt  = 2'd0;
        irq_pending_nxt    = 1'b0;
        touching_count_nxt = 8'd0;
        now_x_nxt          = 16'd0;
        now_y_nxt          = 16'd0;
        ended              = 1'b1;
      end
    end else begin
      reported_count_nxt = item.finger_count;
      now_x_nxt          = x_pt;
      now_y_nxt          = y_pt;
      if (on_panel) begin
        // Latch the start point on first contact
        if (touching_count_r == 8'd0) begin
          start_x_nxt        = x_pt;
          start_y_nxt        = y_pt;
          touching_count_nxt = item.finger_count;
          began              = 1'b1;
        end
        end_x_nxt = x_pt;
        end_y_nxt = y_pt;
      end
    end
  end

  // Classify against the updated points
  always_comb begin
    if (touching_count_nxt == 8'd0) begin
      cls = (ttrk_pkg::near_pt(start_x_nxt, end_x_nxt) &&
             ttrk_pkg::near_pt(start_y_nxt, end_y_nxt)) ?
            ttrk_pkg::CLS_CLICK : ttrk_pkg::CLS_SLIDED;
    end else begin
      cls = (ttrk_pkg::near_pt(start_x_nxt, now_x_nxt) &&
             ttrk_pkg::near_pt(start_y_nxt, now_y_nxt)) ?
            ttrk_pkg::CLS_PRESSED : ttrk_pkg::CLS_SLIDED;
    end
  end

  // Result for the item being stepped
  always_comb begin
    res.touch_state = reported_count_nxt;
    res.start_x     = start_x_nxt;
    res.start_y     = start_y_nxt;
    res.now_x       = now_x_nxt;
    res.now_y       = now_y_nxt;
    res.end_x       = end_x_nxt;
    res.end_y       = end_y_nxt;
    res.slide_class = cls;
    res.touch_began = began;
    res.touch_ended = ended;
  end

  // Advance the state once per stepped item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_pending_r    <= 1'b0;
      release_count_r  <= 2'd0;
      touching_count_r <= 8'd0;
      reported_count_r <= 8'd0;
      start_x_r        <= 16'd0;
      start_y_r        <= 16'd0;
      now_x_r          <= 16'd0;
      now_y_r          <= 16'd0;
      end_x_r          <= 16'd0;
      end_y_r          <= 16'd0;
    end else if (step_en) begin
      irq_pending_r    <= irq_pending_nxt;
      release_count_r  <= release_count_nxt;
      touching_count_r <= touching_count_nxt;
      reported_count_r <= reported_count_nxt;
      start_x_r        <= start_x_nxt;
      start_y_r        <= start_y_nxt;
      now_x_r          <= now_x_nxt;
      now_y_r          <= now_y_nxt;
      end_x_r          <= end_x_nxt;
      end_y_r          <= end_y_nxt;
    end
  end

endmodule

[hw/rtl/touch_point_tracker_top.sv]
// Top level of the touch point tracker: input register, tracker core,
// result register and configuration port.
// Depends on ttrk_pkg, ttrk_cfg and ttrk_core.
//
//   Channel  Direction  Handshake              Payload
//   in_      slave      in_tvalid / in_tready  in_tdata (40b), in_tuser (mode)
//   out_     master     out_tvalid/out_tready  out_tdata (112b)
//   cfg_     slave      cfg_valid / cfg_ready  cfg_index (3b), cfg_data (13b)
//
// One item per cycle sustained while out_tready is high; each item passes
// through the input register, then the core update that loads the result
// register. Reset (rst_n low, synchronous) clears the tracker state, empties
// both registers and loads the configuration defaults. A stalled result
// holds in the result register while the input register still takes one
// more item; in_tready drops only when both are full.
// Configuration writes are taken every cycle.
`timescale 1ns / 1ps

module touch_point_tracker_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [7:0] finger_count, [15:8] x_high_byte, [23:16] x_low_byte,
  // [31:24] y_high_byte, [39:32] y_low_byte
  input  logic [39:0]  in_tdata,
  // [0] mode
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] touch_state, [23:8] start_x, [39:24] start_y, [55:40] now_x,
  // [71:56] now_y, [87:72] end_x, [103:88] end_y, [105:104] slide_class,
  // [106] touch_began, [107] touch_ended, [111:108] zero
  output logic [111:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [12:0]  cfg_data
);

  ttrk_pkg::ttrk_cfg_t    cfg;
  ttrk_pkg::ttrk_item_t   item_r;
  ttrk_pkg::ttrk_result_t res;
  ttrk_pkg::ttrk_result_t res_r;
  logic                   in_vld_r;
  logic                   out_vld_r;
  logic                   step;
  logic                   in_xfer;

  // Configuration registers
  assign cfg_ready = 1'b1;

  ttrk_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the held item when the result register is free or draining
  assign step      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || step;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.mode         <= in_tuser;
      item_r.finger_count <= in_tdata[7:0];
      item_r.x_high_byte  <= in_tdata[15:8];
      item_r.x_low_byte   <= in_tdata[23:16];
      item_r.y_high_byte  <= in_tdata[31:24];
      item_r.y_low_byte   <= in_tdata[39:32];
    end
  end

  ttrk_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, res_r.touch_ended, res_r.touch_began, res_r.slide_class,
                       res_r.end_y, res_r.end_x, res_r.now_y, res_r.now_x,
                       res_r.start_y, res_r.start_x, res_r.touch_state};

endmodule

[bench/testbench.sv]
// Self-checking bench for touch_point_tracker_top: directed touches, then random
// gestures under several panel settings with random and forced back-pressure.
// Depends on ttrk_pkg and the tracker RTL.
`timescale 1ns / 1ps

module testbench;
  import ttrk_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 8;

  // Mirror of the tracker: panel settings, touch state, reports not yet seen
  class touch_tracker_model;
    logic         swap, flip_x, flip_y;
    logic [15:0]  width, height;
    logic         irq_armed;
    logic [1:0]   zero_polls;
    logic [7:0]   touching, reported;
    logic [15:0]  start_pt[2], now_pt[2], end_pt[2];
    ttrk_result_t expected_reports[$];
    int           errors, began_total, ended_total;

    function new();
      swap = 1'b0;
      flip_x = 1'b0;
      flip_y = 1'b0;
      width = {3'b0, PANEL_WIDTH_RST};
      height = {3'b0, PANEL_HEIGHT_RST};
      irq_armed = 1'b0;
      zero_polls = '0;
      touching = '0;
      reported = '0;
      start_pt = '{16'd0, 16'd0};
      now_pt = '{16'd0, 16'd0};
      end_pt = '{16'd0, 16'd0};
      errors = 0;
      began_total = 0;
      ended_total = 0;
    endfunction

    function void write_reg(input cfg_idx_t idx, input logic [12:0] val);
      case (idx)
        CFG_SWAP_AXES:    swap = val[0];
        CFG_FLIP_X:       flip_x = val[0];
        CFG_FLIP_Y:       flip_y = val[0];
        CFG_PANEL_WIDTH:  width = {3'b0, val};
        CFG_PANEL_HEIGHT: height = {3'b0, val};
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // Points within one count of each other on both axes, with 16-bit wrap
    function logic close_pair(input logic [15:0] p[2], input logic [15:0] q[2]);
      logic [15:0] dx, dy;
      dx = p[0] - q[0];
      dy = p[1] - q[1];
      return (dx <= 16'd1 || dx == 16'hffff) && (dy <= 16'd1 || dy == 16'hffff);
    endfunction

    // Advance the touch state by one item and work out its report
    function void accept_item(input ttrk_item_t it);
      ttrk_result_t r;
      logic [7:0]   hi;
      logic [15:0]  a, b, x, y;
      r = '0;
      hi = it.x_high_byte & COORD_HI_MASK;
      a = {hi, it.x_low_byte};
      hi = it.y_high_byte & COORD_HI_MASK;
      b = {hi, it.y_low_byte};
      if (it.mode == MODE_IRQ) begin
        irq_armed = 1'b1;
      end else if (!irq_armed) begin
        reported = '0;
      end else if (it.finger_count == 8'd0) begin
        zero_polls = zero_polls + 2'd1;
        if (zero_polls >= REL_SAMPLES) begin
          zero_polls = '0;
          irq_armed = 1'b0;
          touching = '0;
          now_pt = '{16'd0, 16'd0};
          r.touch_ended = 1'b1;
        end
      end else begin
        x = swap ? b : a;
        y = swap ? a : b;
        reported = it.finger_count;
        if (flip_x) x = width - x;
        if (flip_y) y = height - y;
        now_pt = '{x, y};
        if (x < width && y < height) begin
          if (touching == 8'd0) begin
            start_pt = '{x, y};
            touching = it.finger_count;
            r.touch_began = 1'b1;
          end
          end_pt = '{x, y};
        end
      end
      if (touching == 8'd0)
        r.slide_class = close_pair(start_pt, end_pt) ? CLS_CLICK : CLS_SLIDED;
      else
        r.slide_class = close_pair(start_pt, now_pt) ? CLS_PRESSED : CLS_SLIDED;
      r.touch_state = reported;
      r.start_x = start_pt[0];
      r.start_y = start_pt[1];
      r.now_x = now_pt[0];
      r.now_y = now_pt[1];
      r.end_x = end_pt[0];
      r.end_y = end_pt[1];
      began_total += int'(r.touch_began);
      ended_total += int'(r.touch_ended);
      expected_reports.push_back(r);
    endfunction

    function string show(input ttrk_result_t r);
      return $sformatf("cnt=%0d start=(%0d,%0d) now=(%0d,%0d) end=(%0d,%0d) cls=%0d b=%0d e=%0d",
                       r.touch_state, r.start_x, r.start_y, r.now_x, r.now_y,
                       r.end_x, r.end_y, r.slide_class, r.touch_began, r.touch_ended);
    endfunction

    // Compare one report from the block with the oldest prediction
    function void check_report(input ttrk_result_t got);
      ttrk_result_t want;
      logic         bad;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb: report with none predicted: %s", show(got));
        return;
      end
      want = expected_reports.pop_front();
      bad = (got.touch_state !== want.touch_state) || (got.start_x !== want.start_x) ||
            (got.start_y !== want.start_y) || (got.now_x !== want.now_x) ||
            (got.now_y !== want.now_y) || (got.end_x !== want.end_x) ||
            (got.end_y !== want.end_y) || (got.slide_class !== want.slide_class) ||
            (got.touch_began !== want.touch_began) || (got.touch_ended !== want.touch_ended);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("tb: mismatch at %0t", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [12:0]  cfg_data = '0;

  touch_tracker_model tracker = new();
  ttrk_result_t       seen;
  int                 cycle_count = 0;
  int                 items_sent = 0;
  int                 reports_seen = 0;
  int                 reg_writes = 0;
  int                 tx_idle_pct = 0;
  int                 rx_idle_pct = 0;
  int                 phase_no = 0;
  logic               rx_hold = 1'b0;

  touch_point_tracker_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the next ready value
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.touch_state = out_tdata[7:0];
        seen.start_x = out_tdata[23:8];
        seen.start_y = out_tdata[39:24];
        seen.now_x = out_tdata[55:40];
        seen.now_y = out_tdata[71:56];
        seen.end_x = out_tdata[87:72];
        seen.end_y = out_tdata[103:88];
        seen.slide_class = out_tdata[105:104];
        seen.touch_began = out_tdata[106];
        seen.touch_ended = out_tdata[107];
        tracker.check_report(seen);
        reports_seen++;
      end
      if (rx_hold) out_tready <= 1'b0;
      else out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Long receiver stall in the no-idle phase so both item registers fill up
  initial begin
    wait (phase_no == 3);
    repeat (30) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Offer one item and hold it until the transfer, then maybe idle
  task automatic send_item(input ttrk_item_t it);
    in_tuser <= it.mode;
    in_tdata <= {it.y_low_byte, it.y_high_byte, it.x_low_byte, it.x_high_byte,
                 it.finger_count};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    tracker.accept_item(it);
    items_sent++;
    // Idle the sender cycle by cycle at the phase's rate
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic ttrk_item_t irq_item();
    ttrk_item_t it;
    it = ttrk_item_t'({$urandom, $urandom});
    it.mode = MODE_IRQ;
    return it;
  endfunction

  // Poll carrying raw coordinates; the unused high nibbles get random bits
  function automatic ttrk_item_t poll_item(input int fingers, input int a, input int b);
    ttrk_item_t  it;
    logic [11:0] ca, cb;
    ca = a[11:0];
    cb = b[11:0];
    it.mode = MODE_POLL;
    it.finger_count = fingers[7:0];
    it.x_high_byte = {4'($urandom), ca[11:8]};
    it.x_low_byte = ca[7:0];
    it.y_high_byte = {4'($urandom), cb[11:8]};
    it.y_low_byte = cb[7:0];
    return it;
  endfunction

  // Raw coordinate range that mostly lands on the current panel
  function automatic int coord_span();
    int lim;
    lim = int'((tracker.width < tracker.height) ? tracker.width : tracker.height);
    if (lim == 0) lim = 15;
    if (lim > 4095) lim = 4095;
    return lim;
  endfunction

  // One touch: interrupt, a few samples that wander, then a debounced release
  task automatic touch_gesture();
    int lim, cx, cy, fingers;
    lim = coord_span();
    if ($urandom_range(5) == 0) send_item(poll_item($urandom_range(1, 5), 1, 1));
    send_item(irq_item());
    cx = $urandom_range(lim);
    cy = $urandom_range(lim);
    fingers = ($urandom_range(9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 5);
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(9))
        0: begin
          cx = $urandom_range(lim);
          cy = $urandom_range(lim);
        end
        1: send_item(poll_item(0, $urandom, $urandom));
        2: send_item(irq_item());
        3: begin
          cx = $urandom_range(4095);
          cy = $urandom_range(4095);
        end
        default: begin
          cx = (cx + $urandom_range(4) - 2) & 12'hfff;
          cy = (cy + $urandom_range(4) - 2) & 12'hfff;
        end
      endcase
      send_item(poll_item(fingers, cx, cy));
    end
    repeat (2) send_item(poll_item(0, $urandom, $urandom));
  endtask

  task automatic random_phase(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(7) == 0) send_item(ttrk_item_t'({$urandom, $urandom}));
      else touch_gesture();
    end
  endtask

  // Wait until every report is back and the pipeline has settled
  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five registers back to back; valid drops once at the end
  task automatic set_panel(input logic swap, input logic fx, input logic fy,
                           input logic [12:0] w, input logic [12:0] h);
    cfg_idx_t    idx[5];
    logic [12:0] val[5];
    idx = '{CFG_SWAP_AXES, CFG_FLIP_X, CFG_FLIP_Y, CFG_PANEL_WIDTH, CFG_PANEL_HEIGHT};
    val = '{{12'd0, swap}, {12'd0, fx}, {12'd0, fy}, w, h};
    for (int i = 0; i < 5; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      tracker.write_reg(idx[i], val[i]);
      reg_writes++;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed touches on the reset panel
    send_item(poll_item(3, 10, 10));
    send_item(irq_item());
    send_item(poll_item(1, 0, 0));
    send_item(poll_item(1, 1, 0));
    send_item(poll_item(2, 239, 279));
    send_item(poll_item(1, 240, 5));
    send_item(poll_item(1, 5, 280));
    send_item(ttrk_item_t'({MODE_POLL, 40'hff_ffff_ffff}));
    send_item(poll_item(0, 7, 7));
    send_item(poll_item(4, 2, 2));
    send_item(poll_item(0, 9, 9));
    send_item(irq_item());
    send_item(irq_item());
    send_item(poll_item(1, 100, 100));
    send_item(poll_item(1, 101, 99));
    send_item(poll_item(0, 0, 0));
    send_item(poll_item(0, 0, 0));
    send_item(poll_item(0, 0, 0));
    send_item(ttrk_item_t'({MODE_IRQ, 40'h0}));
    send_item(poll_item(1, 50, 50));
    send_item(poll_item(1, 60, 50));
    send_item(poll_item(0, 0, 0));
    send_item(poll_item(0, 0, 0));
    send_item(ttrk_item_t'({MODE_POLL, 40'h0}));
    drain();

    // Swapped axes, mirrored x, full-size panel; slow receiver
    phase_no = 1;
    set_panel(1'b1, 1'b1, 1'b0, 13'd4096, 13'd4096);
    tx_idle_pct = 17;
    rx_idle_pct <= 87;
    random_phase(220);
    drain();

    // Mirrored y, one-pixel-wide panel, oversize height; slow sender
    phase_no = 2;
    set_panel(1'b0, 1'b0, 1'b1, 13'd1, 13'd8191);
    tx_idle_pct = 87;
    rx_idle_pct <= 17;
    random_phase(220);
    drain();

    // Both mirrors on a small landscape panel; no idling, one long stall
    phase_no = 3;
    set_panel(1'b0, 1'b1, 1'b1, 13'd320, 13'd240);
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    random_phase(220);
    drain();

    // Zero width rejects every sample
    phase_no = 4;
    set_panel(1'b1, 1'b0, 1'b0, 13'd0, 13'd8191);
    random_phase(40);
    drain();

    tracker.errors += tracker.pending();
    $display("tb: %0d items, %0d reports, %0d register writes over 5 panel settings",
             items_sent, reports_seen, reg_writes);
    $display("tb: %0d touches began, %0d releases, %0d mismatches",
             tracker.began_total, tracker.ended_total, tracker.errors);
    if (tracker.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
